>>> sv/bhrt_pkg.sv
package bhrt_pkg;

    // Field widths of one scan transaction and one result transaction.
    localparam int PORT_W       = 16;
    localparam int QUERY_W      = 4;
    localparam int CNT_W        = 16;
    localparam int KEY_W        = 7;
    localparam int BTN_IDX_W    = 5;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 32;

    // Only this many buttons are searched for a keypad character.
    localparam int KEY_SCAN_LIMIT = 22;

    localparam logic [CNT_W-1:0] COUNT_MAX    = 16'hFFFE;
    localparam logic [CNT_W-1:0] RELEASE_MARK = 16'hFFFF;

    localparam logic [KEY_W-1:0] CHAR_ONE   = 7'h31;
    localparam logic [KEY_W-1:0] CHAR_STAR  = 7'h2A;
    localparam logic [KEY_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [KEY_W-1:0] CHAR_HASH  = 7'h23;
    localparam logic [KEY_W-1:0] CHAR_A     = 7'h41;
    localparam logic [KEY_W-1:0] CHAR_NONE  = 7'h00;

    localparam logic [BTN_IDX_W-1:0] BTN_STAR = 5'd9;
    localparam logic [BTN_IDX_W-1:0] BTN_ZERO = 5'd10;
    localparam logic [BTN_IDX_W-1:0] BTN_HASH = 5'd11;
    localparam logic [BTN_IDX_W-1:0] BTN_A    = 5'd12;
    localparam logic [BTN_IDX_W-1:0] BTN_END  = 5'd16;

    // Number of restoring-division steps, one quotient bit per step.
    localparam int DIV_STEPS  = CNT_W;
    localparam int DIV_STEP_W = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic scan;
        logic read;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

    // Keypad character of a button.
    function automatic logic [KEY_W-1:0] key_of(input logic [BTN_IDX_W-1:0] idx);
        logic [KEY_W-1:0] k;
        k = CHAR_NONE;
        if (idx < BTN_STAR) begin
            k = CHAR_ONE + KEY_W'(idx);
        end else if (idx == BTN_STAR) begin
            k = CHAR_STAR;
        end else if (idx == BTN_ZERO) begin
            k = CHAR_ZERO;
        end else if (idx == BTN_HASH) begin
            k = CHAR_HASH;
        end else if (idx < BTN_END) begin
            k = CHAR_A + KEY_W'(idx - BTN_A);
        end
        return k;
    endfunction

endpackage

>>> sv/bhrt_ctrl.sv
module bhrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output bhrt_pkg::t_cmd o_cmd,
    input  bhrt_pkg::t_sts i_sts
);
    import bhrt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_READ = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

>>> sv/bhrt_dp.sv
module bhrt_dp #(
    parameter int BUTTON_COUNT = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bhrt_pkg::t_cmd                     i_cmd,
    output bhrt_pkg::t_sts                     o_sts,
    input  logic [bhrt_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [bhrt_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import bhrt_pkg::*;

    localparam int LVL_W = (BUTTON_COUNT > PORT_W) ? BUTTON_COUNT : PORT_W;

    // Captured scan transaction.
    logic               r_mode;
    logic [PORT_W-1:0]  r_port;
    logic [QUERY_W-1:0] r_query;
    logic [CNT_W-1:0]   r_period;
    logic [CNT_W-1:0]   r_htime;

    logic [CNT_W-1:0]   r_counters [BUTTON_COUNT];

    // Queried counter, key character and divider state.
    logic [CNT_W-1:0]      r_cnt;
    logic [KEY_W-1:0]      r_key;
    logic [CNT_W-1:0]      r_dividend;
    logic [CNT_W-1:0]      r_rem;
    logic [DIV_STEP_W-1:0] r_step;

    // Result register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [LVL_W-1:0]       levels;
    logic [CNT_W-1:0]       sel_cnt;
    logic [KEY_W-1:0]       first_key;
    logic [CNT_W:0]         trial;
    logic [CNT_W:0]         trial_sub;
    logic                   press_edge;
    logic                   release_edge;
    logic                   hold_match;
    logic                   repeat_hit;
    logic [CNT_W-1:0]       held_scans;

    // Buttons without a port bit read as released (pulled high).
    assign levels = {{(LVL_W-PORT_W){1'b1}}, r_port};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode   <= i_s_tdata[0];
            r_port   <= i_s_tdata[16:1];
            r_query  <= i_s_tdata[20:17];
            r_period <= i_s_tdata[36:21];
            r_htime  <= i_s_tdata[52:37];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_counters[i] <= '0;
            end
        end else if (i_cmd.scan && !r_mode) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                if (!levels[i]) begin
                    if (r_counters[i] < COUNT_MAX) begin
                        r_counters[i] <= r_counters[i] + CNT_W'(1);
                    end else if (r_counters[i] == RELEASE_MARK) begin
                        r_counters[i] <= CNT_W'(1);
                    end
                end else if (r_counters[i] != '0) begin
                    r_counters[i] <= (r_counters[i] == RELEASE_MARK) ? '0 : RELEASE_MARK;
                end
            end
        end
    end

    // A query beyond the button count reads as an idle counter.
    always_comb begin
        sel_cnt = '0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            if ({1'b0, r_query} == BTN_IDX_W'(i)) begin
                sel_cnt = r_counters[i];
            end
        end
    end

    // Lowest-numbered released button wins.
    always_comb begin
        first_key = CHAR_NONE;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            if (i < KEY_SCAN_LIMIT && r_counters[i] == RELEASE_MARK) begin
                first_key = key_of(BTN_IDX_W'(i));
            end
        end
    end

    // Restoring division for the remainder, one dividend bit per step.
    assign trial     = {r_rem, r_dividend[CNT_W-1]};
    assign trial_sub = trial - {1'b0, r_period};

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_cnt      <= sel_cnt;
            r_key      <= first_key;
            r_dividend <= sel_cnt;
            r_rem      <= '0;
            r_step     <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[CNT_W-2:0], 1'b0};
            r_rem      <= trial_sub[CNT_W] ? trial[CNT_W-1:0] : trial_sub[CNT_W-1:0];
            r_step     <= r_step + DIV_STEP_W'(1);
        end
    end

    assign o_sts.div_last = (r_step == DIV_STEP_W'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign press_edge   = (r_cnt == CNT_W'(1));
    assign release_edge = (r_cnt == RELEASE_MARK);
    assign hold_match   = ({1'b0, r_cnt} == ({1'b0, r_htime} + (CNT_W+1)'(1)));
    assign held_scans   = release_edge ? '0 : r_cnt;

    always_comb begin
        if (release_edge) begin
            repeat_hit = 1'b0;
        end else if (r_period <= CNT_W'(1)) begin
            repeat_hit = (r_cnt != '0);
        end else begin
            repeat_hit = (r_rem == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {5'b0, r_key, held_scans, repeat_hit, hold_match,
                           release_edge, press_edge};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> sv/button_hold_repeat_tracker.sv
// Channel  | Dir | Fields in tdata, lowest bit first
// ---------+-----+----------------------------------------------------------
// s (scan) | in  | mode[0], port_bits[16:1], query_button[20:17],
//          |     | repeat_period[36:21], hold_time[52:37], zero[55:53]
// m (rslt) | out | press_edge[0], release_edge[1], hold_match[2],
//          |     | repeat_hit[3], held_scans[19:4], key_char[26:20], zero[31:27]
//
// Each scan transaction runs from acceptance to a loaded result through an
// accept step, a scan step, a counter read step and 16 steps of the
// bit-serial remainder unit, then a result load.
// Reset (i_rst_n low at a clock edge) clears all hold counters to idle and
// empties the result register. The result register lets the next scan be
// accepted while a result waits; a stalled result only holds the block at
// the final load step.
module button_hold_repeat_tracker #(
    parameter int BUTTON_COUNT = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // mode, port_bits, query_button, repeat_period, hold_time, zero fill
    input  logic [bhrt_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // press_edge, release_edge, hold_match, repeat_hit, held_scans, key_char,
    // zero fill
    output logic [bhrt_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import bhrt_pkg::*;

    // The controller sequences scan, read, divide and load; the datapath
    // holds the counters, the remainder unit and the result register.
    t_cmd cmd;
    t_sts sts;

    bhrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bhrt_dp #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;
    import bhrt_pkg::*;

    // The block is built with its default of 16 buttons, one per port bit.
    localparam int BUTTONS         = 16;
    // Cycles after the last result is checked before the run is closed.
    localparam int DRAIN_CYCLES    = 40;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int HOLD_OFF_CYCLES = 400;
    // The slowest correct stretch without any transaction is the hold-off plus
    // the longest sender gap plus one trip through the block. Allow several
    // times that before giving up.
    localparam int STALL_LIMIT     = 3000;
    localparam int RANDOM_SCANS    = 650;
    localparam int PRESSURE_AT     = 300;

    // One scan transaction as the sender sees it.
    typedef struct {
        logic               mode;
        logic [PORT_W-1:0]  port;
        logic [QUERY_W-1:0] query;
        logic [CNT_W-1:0]   period;
        logic [CNT_W-1:0]   hold;
    } t_scan;

    // One result transaction, split into its fields.
    typedef struct {
        logic             prs_edge;
        logic             rel_edge;
        logic             hold_match;
        logic             rep_hit;
        logic [CNT_W-1:0] held;
        logic [KEY_W-1:0] key;
    } t_report;

    // Keeps its own copy of the hold counters, works out the report that each
    // accepted scan must produce, and checks the reports in order.
    class hold_result_board;
        logic [CNT_W-1:0] hold_cnt [BUTTONS];
        t_report          due_reports [$];
        int               errors;

        function new();
            foreach (hold_cnt[i]) hold_cnt[i] = '0;
            due_reports.delete();
            errors = 0;
        endfunction

        function logic [KEY_W-1:0] char_for(int idx);
            if (idx < 9) return CHAR_ONE + KEY_W'(idx);
            if (idx == 9) return CHAR_STAR;
            if (idx == 10) return CHAR_ZERO;
            if (idx == 11) return CHAR_HASH;
            if (idx < 16) return CHAR_A + KEY_W'(idx - 12);
            return CHAR_NONE;
        endfunction

        function void take_scan(t_scan s);
            logic [CNT_W-1:0] c;
            logic [CNT_W:0]   target;
            t_report          r;
            if (s.mode == 1'b0) begin
                for (int i = 0; i < BUTTONS; i++) begin
                    c = hold_cnt[i];
                    if (s.port[i] == 1'b0) begin
                        // Pressed: count up, stop at the top, restart after a release.
                        if (c < COUNT_MAX) begin
                            c = c + CNT_W'(1);
                        end else if (c == RELEASE_MARK) begin
                            c = 16'd1;
                        end
                    end else if (c != '0) begin
                        // Let go: mark the release once, then fall back to idle.
                        c = (c == RELEASE_MARK) ? '0 : RELEASE_MARK;
                    end
                    hold_cnt[i] = c;
                end
            end
            c = hold_cnt[s.query];
            r.prs_edge = (c == 16'd1);
            r.rel_edge = (c == RELEASE_MARK);
            // The match is taken one bit wider, so a hold time of all ones never hits.
            target = {1'b0, s.hold} + 17'd1;
            r.hold_match = ({1'b0, c} == target);
            if (c == RELEASE_MARK) begin
                r.rep_hit = 1'b0;
            end else if (s.period <= 16'd1) begin
                r.rep_hit = (c != '0);
            end else begin
                r.rep_hit = ((c % s.period) == 16'd1);
            end
            r.held = (c == RELEASE_MARK) ? '0 : c;
            r.key = CHAR_NONE;
            for (int i = BUTTONS - 1; i >= 0; i--) begin
                if (hold_cnt[i] == RELEASE_MARK) r.key = char_for(i);
            end
            due_reports.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [OUT_TDATA_W-1:0] d);
            t_report e;
            if (due_reports.size() == 0) begin
                $error("result transaction with no report pending: tdata=%h", d);
                errors++;
                return;
            end
            e = due_reports.pop_front();
            compare_field("press_edge", 32'(e.prs_edge), 32'(d[0]));
            compare_field("release_edge", 32'(e.rel_edge), 32'(d[1]));
            compare_field("hold_match", 32'(e.hold_match), 32'(d[2]));
            compare_field("repeat_hit", 32'(e.rep_hit), 32'(d[3]));
            compare_field("held_scans", 32'(e.held), 32'(d[19:4]));
            compare_field("key_char", 32'(e.key), 32'(d[26:20]));
            compare_field("zero_fill", 0, 32'(d[31:27]));
        endfunction

        function int pending();
            return due_reports.size();
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // mode, port_bits, query_button, repeat_period, hold_time, zero fill
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // press_edge, release_edge, hold_match, repeat_hit, held_scans, key_char,
    // zero fill
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    hold_result_board book;

    // Set by the sender to ask the receiver for its long hold-off; the receiver
    // raises the second flag for as long as the hold-off lasts.
    bit rx_hold_req = 1'b0;
    bit rx_holding  = 1'b0;
    int idle_cycles = 0;

    button_hold_repeat_tracker #(
        .BUTTON_COUNT (BUTTONS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle stretches for both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one scan transaction and returns at the edge where it is taken.
    // The valid is only lowered when a gap is wanted, so back-to-back
    // transactions keep it high without a drop inside one time step.
    task automatic send_scan(input t_scan s);
        int gap;
        gap = pick_gap();
        if (rx_hold_req || rx_holding) gap = 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, s.hold, s.period, s.query, s.port, s.mode};
        do @(posedge i_clk); while (!o_s_tready);
        book.take_scan(s);
    endtask

    task automatic issue(input logic mode, input logic [PORT_W-1:0] port,
                         input logic [QUERY_W-1:0] query,
                         input logic [CNT_W-1:0] period, input logic [CNT_W-1:0] hold);
        t_scan s;
        s.mode   = mode;
        s.port   = port;
        s.query  = query;
        s.period = period;
        s.hold   = hold;
        send_scan(s);
    endtask

    // Result side. Outputs are sampled at the rising edge, before the block's
    // own updates of that edge take effect, so the check sees settled values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            book.check_report(o_m_tdata);
        end
    end

    // Receiver readiness. Random gaps and runs, plus the one long hold-off
    // that the sender asks for while it keeps offering scans back to back, so
    // the result register and the pipeline fill and the input stalls.
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                rx_holding  = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: counts cycles in which no transaction happens on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        logic [PORT_W-1:0]  want_down;
        logic [QUERY_W-1:0] q;
        logic [CNT_W-1:0]   per;
        logic [CNT_W-1:0]   hold;
        logic               mode;
        int                 r;
        int                 pick;

        book = new();
        want_down = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // Report only straight after reset: every counter idle, no key.
        issue(1'b1, 16'hFFFF, 4'd0, 16'd0, 16'hFFFF);
        // A scan with nothing pressed leaves everything idle.
        issue(1'b0, 16'hFFFF, 4'd15, 16'hFFFF, 16'd0);
        // Button 0 goes down: press edge, hold time zero matches, period zero repeats.
        issue(1'b0, 16'hFFFE, 4'd0, 16'd0, 16'd0);
        // Second scan held: count 2, period one repeats every scan.
        issue(1'b0, 16'hFFFE, 4'd0, 16'd1, 16'd1);
        // Count 3 against period 2 gives a repeat hit; hold time all ones never matches.
        issue(1'b0, 16'hFFFE, 4'd0, 16'd2, 16'hFFFF);
        // Count 4 against the largest period gives no hit.
        issue(1'b0, 16'hFFFE, 4'd0, 16'hFFFF, 16'd3);
        // Report only: the counter stays at 4, and 4 mod 3 is 1.
        issue(1'b1, 16'h0000, 4'd0, 16'd3, 16'd3);
        // Let go: release edge, key '1', no repeat on the release marker.
        issue(1'b0, 16'hFFFF, 4'd0, 16'd0, 16'hFFFE);
        // Pressed again right after the release: the count restarts at 1.
        issue(1'b0, 16'hFFFE, 4'd0, 16'd0, 16'd0);
        // All buttons down at once, then released from the top, so the key
        // walks through the letters and symbols of the pad.
        issue(1'b0, 16'h0000, 4'd15, 16'd5, 16'd0);
        issue(1'b0, 16'h8000, 4'd15, 16'd5, 16'd1);
        issue(1'b0, 16'h9000, 4'd12, 16'd5, 16'd1);
        issue(1'b0, 16'h9800, 4'd11, 16'd2, 16'd2);
        issue(1'b0, 16'h9C00, 4'd10, 16'd2, 16'd3);
        issue(1'b0, 16'h9E00, 4'd9, 16'd3, 16'd4);
        issue(1'b0, 16'hBE00, 4'd13, 16'd4, 16'd5);
        // Report only while a release marker is pending.
        issue(1'b1, 16'h1234, 4'd13, 16'd0, 16'd5);
        issue(1'b0, 16'hFFFF, 4'd4, 16'd7, 16'd6);
        // Everything idle again: no key.
        issue(1'b0, 16'hFFFF, 4'd8, 16'd0, 16'd0);

        // Random part. Most scans follow a held-button pattern that changes a
        // few buttons at a time, so presses are held for a while, released,
        // and cleared; the rest are fully random transactions.
        for (int n = 0; n < RANDOM_SCANS; n++) begin
            if (n == PRESSURE_AT) rx_hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                mode      = 1'($urandom_range(0, 1));
                want_down = PORT_W'($urandom_range(0, 16'hFFFF));
                q         = QUERY_W'($urandom_range(0, BUTTONS - 1));
                per       = CNT_W'($urandom_range(0, 16'hFFFF));
                hold      = CNT_W'($urandom_range(0, 16'hFFFF));
            end else begin
                for (int b = 0; b < BUTTONS; b++) begin
                    if ($urandom_range(0, 11) == 0) want_down[b] = ~want_down[b];
                end
                mode = ($urandom_range(0, 6) == 0);
                // Prefer a button with something going on.
                q = QUERY_W'($urandom_range(0, BUTTONS - 1));
                for (int t = 0; t < 4; t++) begin
                    if (book.hold_cnt[q] == '0) q = QUERY_W'($urandom_range(0, BUTTONS - 1));
                end
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    per = CNT_W'($urandom_range(0, 1));
                end else if (pick < 9) begin
                    per = CNT_W'($urandom_range(2, 12));
                end else begin
                    per = CNT_W'($urandom_range(0, 16'hFFFF));
                end
                // A third of the time aim the hold time at the current count,
                // which matches if the button is still held after this scan.
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    hold = book.hold_cnt[q];
                end else if (pick == 1) begin
                    hold = CNT_W'($urandom_range(0, 30));
                end else begin
                    hold = CNT_W'($urandom_range(0, 16'hFFFF));
                end
            end
            issue(mode, ~want_down, q, per, hold);
        end
        i_s_tvalid <= 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/bhrt_pkg.sv
sv/bhrt_ctrl.sv
sv/bhrt_dp.sv
sv/button_hold_repeat_tracker.sv
tb/tb_top.sv
